[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by planar_odometry_integrator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define POI_ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define POI_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define POI_ASSERT_PROP(lbl, clk, rstn, prop)
`define POI_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[design/poi_pkg.sv]
// ----------------------------------------------------------------------------
// poi_pkg
// Types, constants and helper functions of the planar odometry integrator.
// ----------------------------------------------------------------------------
package poi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int XY_W             = 34;
    localparam int MUL_W            = 33;
    localparam int PROD_W           = 2 * MUL_W;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic signed [XY_W-1:0] CORDIC_KINV_Q30 = 34'sd652032874;
    localparam logic [15:0] GAIN_RESET = 16'd4096;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SX, ST_SY, ST_SYW, ST_CWAIT,
        ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10,
        ST_QWAIT, ST_LOAD
    } poi_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic                   done;
        logic                   busy;
        logic signed [XY_W-1:0] cos_v;
        logic signed [XY_W-1:0] sin_v;
    } cordic_rsp_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933405;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10680350;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41721;
            5'd15: r = 32'd20860;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2607;
            5'd19: r = 32'd1303;
            5'd20: r = 32'd651;
            5'd21: r = 32'd325;
            5'd22: r = 32'd162;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [23:0] sat_s24(input logic signed [PROD_W-1:0] v);
        logic [23:0] r;
        if (v > 66'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (v < -66'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [PROD_W-1:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'h7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] to_q15(input logic signed [XY_W-1:0] v);
        logic signed [XY_W:0] t;
        logic [15:0] r;
        t = ($signed({v[XY_W-1], v}) + 35'sd16384) >>> 15;
        if (t > 35'sd32767) begin
            r = 16'h7FFF;
        end else if (t < -35'sd32768) begin
            r = 16'h8000;
        end else begin
            r = t[15:0];
        end
        return r;
    endfunction

endpackage

[design/poi_mul.sv]
// ----------------------------------------------------------------------------
// poi_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module poi_mul
    import poi_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

[design/poi_cordic.sv]
// ----------------------------------------------------------------------------
// poi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module poi_cordic
    import poi_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);

    localparam int CW = $clog2(STEPS + 1);

    logic                   busy_reg, done_reg, flip_reg;
    logic [CW-1:0]          cnt_reg;
    logic signed [XY_W-1:0] x_reg, y_reg, z_reg;

    logic [31:0]            ang_sum, ang_in;
    logic                   flip_in;
    logic signed [XY_W-1:0] z_init, x_sh, y_sh, at, x_next, y_next, z_next;

    always_comb begin
        ang_sum = req.angle + 32'h4000_0000;
        flip_in = ang_sum[31];
        ang_in  = flip_in ? (req.angle + 32'h8000_0000) : req.angle;
        z_init  = {{(XY_W-32){ang_in[31]}}, ang_in};
        x_sh    = x_reg >>> cnt_reg;
        y_sh    = y_reg >>> cnt_reg;
        at      = {{(XY_W-32){1'b0}}, atan_turn(5'(cnt_reg))};
        if (!z_reg[XY_W-1]) begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - at;
        end else begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg    <= CORDIC_KINV_Q30;
            y_reg    <= '0;
            z_reg    <= z_init;
            flip_reg <= flip_in;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.busy  = busy_reg;
    assign rsp.cos_v = flip_reg ? -x_reg : x_reg;
    assign rsp.sin_v = flip_reg ? -y_reg : y_reg;

endmodule

[design/planar_odometry_integrator.sv]
// ----------------------------------------------------------------------------
// planar_odometry_integrator
// 2-D dead-reckoning odometry: gain, rotation by heading, position and
// heading integration, yaw quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one velocity command per transaction; m_* returns one odometry
//   result per command. cfg_* writes linear_gain (Q4.12) and is always ready;
//   write it only while the block is idle.
//   Each command makes two CORDIC passes on the shared CORDIC unit (heading
//   rotation, then the half-angle quaternion) plus eleven products on the one
//   shared multiplier.
//   s_tready is high only in idle; a new command is taken while a finished
//   result still waits in the output register. If the receiver stalls with a
//   result already waiting, the next command finishes its work and holds
//   until the output register is free.
//   Reset (aresetn low, synchronous) clears position, heading and the last
//   timestamp, and sets linear_gain to 1.0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module planar_odometry_integrator
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,     // linear_gain
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,      // vel_x, vel_y, yaw_rate, timestamp
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [183:0] m_tdata       // pos_x, pos_y, heading_out, quat_z,
                                       // quat_w, scaled_vel_x, scaled_vel_y,
                                       // yaw_rate_out
);

    localparam int PAD = 32 - ANGLE_BITS;

    poi_state_t state_reg, state_next;

    logic [15:0]             gain_reg;
    logic [31:0]             last_time_reg, last_time_next;
    logic [31:0]             world_x_reg, world_x_next, world_y_reg, world_y_next;
    logic [ANGLE_BITS-1:0]   heading_reg, heading_next;
    logic signed [23:0]      vx_reg, vx_next, vy_reg, vy_next, wz_reg, wz_next;
    logic [31:0]             dt_reg, dt_next;
    logic signed [23:0]      sx_reg, sx_next, sy_reg, sy_next;
    logic signed [MUL_W-1:0] c_reg, c_next, s_reg, s_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [MUL_W-1:0] wvx_reg, wvx_next, wvy_reg, wvy_next;
    logic [31:0]             phi_reg, phi_next, lok_reg, lok_next;
    logic [15:0]             qz_reg, qz_next, qw_reg, qw_next;
    logic                    m_valid_reg, m_valid_next;
    logic [183:0]            m_data_reg, m_data_next;

    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod, diff, wsum;
    logic [31:0]              delta32, hq_new;
    logic [ANGLE_BITS-1:0]    head_upd;
    cordic_req_t              cordic_req;
    cordic_rsp_t              cordic_rsp;

    poi_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    poi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cordic_req),
        .rsp     (cordic_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign delta32  = lok_reg + prod[31:0];
    assign head_upd = heading_reg + delta32[31 -: ANGLE_BITS];
    assign hq_new   = {head_upd, {PAD{1'b0}}};

    always_comb begin
        state_next     = state_reg;
        last_time_next = last_time_reg;
        world_x_next   = world_x_reg;
        world_y_next   = world_y_reg;
        heading_next   = heading_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        wz_next        = wz_reg;
        dt_next        = dt_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        c_next         = c_reg;
        s_next         = s_reg;
        acc_next       = acc_reg;
        wvx_next       = wvx_reg;
        wvy_next       = wvy_reg;
        phi_next       = phi_reg;
        lok_next       = lok_reg;
        qz_next        = qz_reg;
        qw_next        = qw_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        op_a           = '0;
        op_b           = '0;
        cordic_req.start = 1'b0;
        cordic_req.angle = {heading_reg, {PAD{1'b0}}};
        diff = '0;
        wsum = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    vx_next        = s_tdata[23:0];
                    vy_next        = s_tdata[47:24];
                    wz_next        = s_tdata[71:48];
                    dt_next        = s_tdata[103:72] - last_time_reg;
                    last_time_next = s_tdata[103:72];
                    state_next     = ST_SX;
                end
            end
            ST_SX: begin
                op_a       = {{(MUL_W-24){vx_reg[23]}}, vx_reg};
                op_b       = {{(MUL_W-16){1'b0}}, gain_reg};
                state_next = ST_SY;
            end
            ST_SY: begin
                sx_next    = sat_s24(prod >>> 12);
                op_a       = {{(MUL_W-24){vy_reg[23]}}, vy_reg};
                op_b       = {{(MUL_W-16){1'b0}}, gain_reg};
                cordic_req.start = 1'b1;
                state_next = ST_SYW;
            end
            ST_SYW: begin
                sy_next    = sat_s24(prod >>> 12);
                state_next = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (cordic_rsp.done) begin
                    c_next     = cordic_rsp.cos_v[MUL_W-1:0];
                    s_next     = cordic_rsp.sin_v[MUL_W-1:0];
                    state_next = ST_M1;
                end
            end
            ST_M1: begin
                op_a       = {{(MUL_W-24){sx_reg[23]}}, sx_reg};
                op_b       = c_reg;
                state_next = ST_M2;
            end
            ST_M2: begin
                acc_next   = prod;
                op_a       = {{(MUL_W-24){sy_reg[23]}}, sy_reg};
                op_b       = s_reg;
                state_next = ST_M3;
            end
            ST_M3: begin
                diff       = (acc_reg - prod) >>> 30;
                wvx_next   = diff[MUL_W-1:0];
                op_a       = {{(MUL_W-24){sx_reg[23]}}, sx_reg};
                op_b       = s_reg;
                state_next = ST_M4;
            end
            ST_M4: begin
                acc_next   = prod;
                op_a       = {{(MUL_W-24){sy_reg[23]}}, sy_reg};
                op_b       = c_reg;
                state_next = ST_M5;
            end
            ST_M5: begin
                diff       = (acc_reg + prod) >>> 30;
                wvy_next   = diff[MUL_W-1:0];
                op_a       = wvx_reg;
                op_b       = {1'b0, dt_reg};
                state_next = ST_M6;
            end
            ST_M6: begin
                wsum = $signed({{(PROD_W-32){world_x_reg[31]}}, world_x_reg})
                       + (prod >>> 16);
                world_x_next = sat_s32(wsum);
                op_a       = wvy_reg;
                op_b       = {1'b0, dt_reg};
                state_next = ST_M7;
            end
            ST_M7: begin
                wsum = $signed({{(PROD_W-32){world_y_reg[31]}}, world_y_reg})
                       + (prod >>> 16);
                world_y_next = sat_s32(wsum);
                op_a       = {{(MUL_W-24){wz_reg[23]}}, wz_reg};
                op_b       = {1'b0, dt_reg};
                state_next = ST_M8;
            end
            ST_M8: begin
                phi_next   = prod[63:32];
                op_a       = {1'b0, prod[31:0]};
                op_b       = {1'b0, INV_TWO_PI_Q32};
                state_next = ST_M9;
            end
            ST_M9: begin
                lok_next   = prod[63:32];
                op_a       = {1'b0, phi_reg};
                op_b       = {1'b0, INV_TWO_PI_Q32};
                state_next = ST_M10;
            end
            ST_M10: begin
                heading_next     = head_upd;
                cordic_req.start = 1'b1;
                cordic_req.angle = {hq_new[31], hq_new[31:1]};
                state_next       = ST_QWAIT;
            end
            ST_QWAIT: begin
                if (cordic_rsp.done) begin
                    qz_next    = to_q15(cordic_rsp.sin_v);
                    qw_next    = to_q15(cordic_rsp.cos_v);
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {wz_reg, sy_reg, sx_reg, qw_reg, qz_reg,
                                    cordic_req.angle[31:16], world_y_reg, world_x_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gain_reg      <= GAIN_RESET;
            last_time_reg <= '0;
            world_x_reg   <= '0;
            world_y_reg   <= '0;
            heading_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_valid) begin
                gain_reg <= cfg_data;
            end
            last_time_reg <= last_time_next;
            world_x_reg   <= world_x_next;
            world_y_reg   <= world_y_next;
            heading_reg   <= heading_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        wz_reg     <= wz_next;
        dt_reg     <= dt_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        c_reg      <= c_next;
        s_reg      <= s_next;
        acc_reg    <= acc_next;
        wvx_reg    <= wvx_next;
        wvy_reg    <= wvy_next;
        phi_reg    <= phi_next;
        lok_reg    <= lok_next;
        qz_reg     <= qz_next;
        qw_reg     <= qw_next;
        m_data_reg <= m_data_next;
    end

    `POI_ASSERT_PROP(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)
    `POI_ASSERT_NEVER(a_cordic_idle, aclk, aresetn, (state_reg == ST_IDLE) && cordic_rsp.busy)
    `POI_ASSERT_PROP(a_load_shows, aclk, aresetn, (state_reg == ST_LOAD && (!m_tvalid || m_tready)) |=> m_tvalid)

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for planar_odometry_integrator. Velocity commands
// are streamed in with random gaps and back-pressure, over several gain
// settings. A bit-accurate odometry predictor in a scoreboard class checks
// every result, field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WDOG_LIMIT = 4000;
    localparam int N_RANDOM   = 930;

    class odom_scoreboard;
        bit [15:0]    gain;
        bit [31:0]    last_ts;
        longint       wx;
        longint       wy;
        bit [15:0]    hdg;
        bit [183:0]   pending[$];
        int           errors;
        int           checked;
        bit [31:0]    atan_tbl[16] = '{
            536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
            10680350, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41721, 20860};

        function new();
            gain = 16'd4096;
            last_ts = 0;
            wx = 0;
            wy = 0;
            hdg = 0;
            errors = 0;
            checked = 0;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void sincos(bit [31:0] ang, output longint c, output longint s);
            bit     flip;
            bit [31:0] t;
            longint x, y, z, nx;
            t = ang + 32'h40000000;
            flip = t[31];
            if (flip) ang = ang + 32'h80000000;
            x = 652032874;
            y = 0;
            z = longint'($signed(ang));
            for (int i = 0; i < 16; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - longint'(atan_tbl[i]);
                end else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + longint'(atan_tbl[i]);
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function bit [15:0] q15(longint v);
            return 16'(clamp((v + 16384) >>> 15, -32768, 32767));
        endfunction

        function void note(bit [103:0] d);
            longint vx, vy, wz, dt, sx, sy, c, s, wvx, wvy, qc, qs;
            bit [63:0] prod;
            bit [31:0] hq, half, dtu;
            bit [183:0] r;
            vx = longint'($signed(d[23:0]));
            vy = longint'($signed(d[47:24]));
            wz = longint'($signed(d[71:48]));
            dtu = d[103:72] - last_ts;
            dt = longint'(dtu);
            last_ts = d[103:72];
            sx = clamp((vx * longint'(gain)) >>> 12, -8388608, 8388607);
            sy = clamp((vy * longint'(gain)) >>> 12, -8388608, 8388607);
            sincos({hdg, 16'h0}, c, s);
            wvx = (sx * c - sy * s) >>> 30;
            wvy = (sx * s + sy * c) >>> 30;
            wx = clamp(wx + ((wvx * dt) >>> 16), -64'sd2147483648, 64'sd2147483647);
            wy = clamp(wy + ((wvy * dt) >>> 16), -64'sd2147483648, 64'sd2147483647);
            prod = 64'(wz * dt) * 64'd683565276;
            hdg = hdg + prod[63:48];
            hq = {hdg, 16'h0};
            half = (hq >> 1) | (hq & 32'h80000000);
            sincos(half, qc, qs);
            r = {24'(wz), 24'(sy), 24'(sx), q15(qc), q15(qs), hq[31:16],
                 32'(wy), 32'(wx)};
            pending.push_back(r);
        endfunction

        function void check(bit [183:0] act);
            bit [183:0] want;
            int lsb[8] = '{0, 32, 64, 80, 96, 112, 136, 160};
            int wid[8] = '{32, 32, 16, 16, 16, 24, 24, 24};
            string nm[8] = '{"pos_x", "pos_y", "heading_out", "quat_z", "quat_w",
                             "scaled_vel_x", "scaled_vel_y", "yaw_rate_out"};
            bit [31:0] e, a;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: result with nothing pending: %h", act);
                return;
            end
            want = pending.pop_front();
            checked++;
            for (int f = 0; f < 8; f++) begin
                e = 32'((want >> lsb[f]) & ((64'd1 << wid[f]) - 1));
                a = 32'((act >> lsb[f]) & ((64'd1 << wid[f]) - 1));
                if (e !== a) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result %0d %s expected %h got %h",
                                 checked, nm[f], e, a);
                end
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [103:0] s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [183:0] m_tdata;

    odom_scoreboard sb = new();
    bit   quiet = 0;
    int   wdog = 0;
    int   n_sent = 0;
    int   n_gains = 0;
    bit [31:0] ts_now = 0;

    always #5 aclk = ~aclk;

    planar_odometry_integrator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 14);
            if (m_tvalid && m_tready) sb.check(m_tdata);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
        end
        if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired, %0d results pending", sb.pending.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send(bit [23:0] vx, bit [23:0] vy, bit [23:0] wz, bit [31:0] ts);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {ts, wz, vy, vx};
        do @(posedge aclk); while (!s_tready);
        sb.note({ts, wz, vy, vx});
        n_sent++;
        if (!quiet && $urandom_range(0, 99) < 14) begin
            gap = $urandom_range(1, 60);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_and_set_gain(bit [15:0] g);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= g;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.gain = g;
        n_gains++;
    endtask

    task automatic random_phase(int n);
        bit [23:0] vx, vy, wz;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 80) begin
                ts_now += $urandom_range(1, 6554);
                vx = 24'($signed($urandom_range(0, 2097152)) - 1048576);
                vy = 24'($signed($urandom_range(0, 2097152)) - 1048576);
                wz = 24'($signed($urandom_range(0, 524288)) - 262144);
            end else begin
                ts_now = $urandom;
                vx = 24'($urandom);
                vy = 24'($urandom);
                wz = 24'($urandom);
            end
            send(vx, vy, wz, ts_now);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // first command after reset, dt measured from zero
        send(24'h010000, 24'h000000, 24'h000000, 32'd0);
        send(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 32'd65536);
        send(24'h800000, 24'h7FFFFF, 24'h800000, 32'd131072);
        send(24'h000000, 24'h000000, 24'h7FFFFF, 32'd131072);
        send(24'h123456, 24'hFEDCBA, 24'h010000, 32'd131073);
        // timestamp going backwards wraps to a huge dt
        send(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'd100);
        send(24'h800000, 24'h800000, 24'h800000, 32'hFFFFFFFF);
        send(24'h000001, 24'hFFFFFF, 24'h000001, 32'h7FFFFFFF);
        send(24'h400000, 24'hC00000, 24'h3243F6, 32'h80010000);
        send(24'hFFFFFF, 24'h000001, 24'hCDBC0A, 32'h80020000);
        drain_and_set_gain(16'hFFFF);
        send(24'h7FFFFF, 24'h800000, 24'h000000, 32'h80030000);
        send(24'h001000, 24'hFFF000, 24'h008000, 32'h80040000);
        send(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 32'h00000000);
        drain_and_set_gain(16'h0000);
        send(24'h7FFFFF, 24'h7FFFFF, 24'h010000, 32'h00010000);
        send(24'h800000, 24'h800000, 24'hFF0000, 32'h00020000);
        drain_and_set_gain(16'd4096);
        send(24'h000000, 24'h000000, 24'h000000, 32'h00020000);
        send(24'h0A0000, 24'h050000, 24'h3243F6, 32'h00030000);
        ts_now = 32'h00030000;
        random_phase(200);
        drain_and_set_gain(16'($urandom));
        quiet = 1;
        random_phase(200);
        quiet = 0;
        drain_and_set_gain(16'hFFFF);
        random_phase(180);
        drain_and_set_gain(16'h0001);
        random_phase(100);
        drain_and_set_gain(16'($urandom));
        random_phase(250);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("sent %0d commands over %0d gain writes, checked %0d results",
                 n_sent, n_gains, sb.checked);
        $display("covered first command, wrapped and zero dt, field extremes, saturation");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/poi_pkg.sv
design/poi_mul.sv
design/poi_cordic.sv
design/planar_odometry_integrator.sv
sim/tb_top.sv
